// ----- hdl/delta_frame_decoder_defines.svh -----
// Assertion macros for the delta frame decoder.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef DELTA_FRAME_DECODER_DEFINES_SVH
`define DELTA_FRAME_DECODER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked out of reset
`define DFD_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define DFD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error(msg);

`else

`define DFD_ASSERT_IMPLY(lbl, clk, rst_n, pre, post, msg)
`define DFD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg)

`endif

`endif

// ----- hdl/dfd_pkg.sv -----
// Shared constants, codes and types of the delta frame decoder.
// No dependencies; the interfaces, decode stage, top level and testbench import it.
package dfd_pkg;

    // Frame geometry and frame store layout (two banks, raster order)
    localparam int FRAME_WIDTH  = 640;
    localparam int FRAME_HEIGHT = 480;
    localparam int BANK_SIZE    = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int STORE_DEPTH  = 2 * BANK_SIZE;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int POS_W        = $clog2(BANK_SIZE);

    // Field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int X_W        = 10;
    localparam int Y_W        = 9;
    localparam int PIX_W      = 16;
    localparam int STATUS_W   = 2;
    localparam int OFFX_W     = 11;
    localparam int OFFY_W     = 10;
    localparam int SX_W       = OFFX_W + 1;
    localparam int SY_W       = OFFY_W + 1;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    // Stream tokens
    localparam logic [BYTE_W-1:0] TOK_COPY_ZERO = 8'd252;
    localparam logic [BYTE_W-1:0] TOK_COPY_A    = 8'd253;
    localparam logic [BYTE_W-1:0] TOK_COPY_B    = 8'd254;
    localparam logic [BYTE_W-1:0] TOK_LITERAL   = 8'd255;

    typedef enum logic [OP_W-1:0] {
        OP_BYTE = 2'd0,
        OP_PULL = 2'd1,
        OP_EOF  = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_BAD_TOKEN = 2'd1,
        ST_OUTSIDE   = 2'd2,
        ST_ORDER     = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_A_X = 2'd0,
        REG_OFFSET_A_Y = 2'd1,
        REG_OFFSET_B_X = 2'd2,
        REG_OFFSET_B_Y = 2'd3
    } t_cfg_reg;

    // Token minus the first token code: the low two bits of the token byte
    typedef enum logic [1:0] {
        KIND_ZERO    = 2'd0,
        KIND_A       = 2'd1,
        KIND_B       = 2'd2,
        KIND_LITERAL = 2'd3
    } t_kind;

    typedef enum logic [4:0] {
        PH_TOKEN  = 5'b00001,
        PH_COUNT  = 5'b00010,
        PH_LIT_LO = 5'b00100,
        PH_LIT_HI = 5'b01000,
        PH_COPY   = 5'b10000
    } t_phase;

    // Item in flight between the decode stage and the output register
    typedef struct packed {
        logic              pixel_valid;
        logic [X_W-1:0]    x;
        logic [Y_W-1:0]    y;
        logic [PIX_W-1:0]  value;
        logic              from_ram;
        logic [ADDR_W-1:0] waddr;
        logic              run_pending;
        t_status           status;
    } t_s1;

    // Linear store distance of an (x, y) offset, modulo the address range
    function automatic logic [ADDR_W-1:0] lin_offset(input logic [OFFX_W-1:0] ox,
                                                     input logic [OFFY_W-1:0] oy);
        logic [ADDR_W-1:0] ex;
        logic [ADDR_W-1:0] ey;
        ex = {{(ADDR_W-OFFX_W){ox[OFFX_W-1]}}, ox};
        ey = {{(ADDR_W-OFFY_W){oy[OFFY_W-1]}}, oy};
        return ADDR_W'(ey * ADDR_W'(FRAME_WIDTH)) + ex;
    endfunction

endpackage

// ----- hdl/dfd_ifs.sv -----
// Channel interfaces of the delta frame decoder: input, result and config.
// Depends on dfd_pkg for field widths.
interface dfd_in_if;
    import dfd_pkg::*;
    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     op;
    logic [BYTE_W-1:0]   data_byte;
    modport source (output valid, output op, output data_byte, input ready);
    modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface dfd_out_if;
    import dfd_pkg::*;
    logic                valid;
    logic                ready;
    logic                pixel_valid;
    logic [X_W-1:0]      pixel_x;
    logic [Y_W-1:0]      pixel_y;
    logic [PIX_W-1:0]    pixel_value;
    logic                run_pending;
    logic [STATUS_W-1:0] status;
    modport source (output valid, output pixel_valid, output pixel_x, output pixel_y,
                    output pixel_value, output run_pending, output status, input ready);
    modport sink   (input valid, input pixel_valid, input pixel_x, input pixel_y,
                    input pixel_value, input run_pending, input status, output ready);
endinterface

interface dfd_cfg_if;
    import dfd_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hdl/dfd_ram.sv -----
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
module dfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- hdl/dfd_ctrl.sv -----
// Decode stage: token parser, write position, bank select, offset registers
// and frame store address generation. Depends on dfd_pkg.
module dfd_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_fire,
    input  logic [dfd_pkg::OP_W-1:0]      i_op,
    input  logic [dfd_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_cfg_we,
    input  logic [dfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dfd_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_rd_en,
    output logic [dfd_pkg::ADDR_W-1:0]    o_rd_addr,
    output dfd_pkg::t_s1                  o_s1
);
    import dfd_pkg::*;

    t_phase            r_phase, n_phase;
    t_kind             r_kind, n_kind;
    logic [BYTE_W-1:0] r_rem, n_rem;
    logic [BYTE_W-1:0] r_lo, n_lo;
    logic [X_W-1:0]    r_x, n_x;
    logic [Y_W-1:0]    r_y, n_y;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_bank, n_bank;

    logic [OFFX_W-1:0] r_ax, r_bx;
    logic [OFFY_W-1:0] r_ay, r_by;
    logic [ADDR_W-1:0] r_lin_a, r_lin_b;

    t_s1               r_s1, n_s1;

    logic              emit;
    logic              copy;
    t_status           status;
    logic [PIX_W-1:0]  lit_val;
    logic [BYTE_W-1:0] rem_dec;

    logic [OFFX_W-1:0] sel_ox;
    logic [OFFY_W-1:0] sel_oy;
    logic [ADDR_W-1:0] sel_lin;
    logic [SX_W-1:0]   sx;
    logic [SY_W-1:0]   sy;
    logic              src_ok;
    logic [ADDR_W-1:0] cur_base, prev_base;

    // Pick the offset of the current copy token
    always_comb begin
        sel_ox  = '0;
        sel_oy  = '0;
        sel_lin = '0;
        case (r_kind)
            KIND_A: begin
                sel_ox  = r_ax;
                sel_oy  = r_ay;
                sel_lin = r_lin_a;
            end
            KIND_B: begin
                sel_ox  = r_bx;
                sel_oy  = r_by;
                sel_lin = r_lin_b;
            end
            default: begin
                sel_ox  = '0;
                sel_oy  = '0;
                sel_lin = '0;
            end
        endcase
    end

    // Source position and its bounds check
    assign sx = {2'b00, r_x} + {sel_ox[OFFX_W-1], sel_ox};
    assign sy = {2'b00, r_y} + {sel_oy[OFFY_W-1], sel_oy};
    assign src_ok = !sx[SX_W-1] && (sx[SX_W-2:0] < (SX_W-1)'(FRAME_WIDTH))
                 && !sy[SY_W-1] && (sy[SY_W-2:0] < (SY_W-1)'(FRAME_HEIGHT));

    assign cur_base  = r_bank ? ADDR_W'(BANK_SIZE) : '0;
    assign prev_base = r_bank ? '0 : ADDR_W'(BANK_SIZE);
    assign rem_dec   = r_rem - 8'd1;

    // Token parser and position update
    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_rem   = r_rem;
        n_lo    = r_lo;
        n_x     = r_x;
        n_y     = r_y;
        n_pos   = r_pos;
        n_bank  = r_bank;
        emit    = 1'b0;
        copy    = 1'b0;
        status  = ST_OK;
        lit_val = '0;
        case (t_op'(i_op))
            OP_BYTE: begin
                case (r_phase)
                    PH_TOKEN: begin
                        if (i_data_byte inside {[TOK_COPY_ZERO:TOK_LITERAL]}) begin
                            n_kind  = t_kind'(i_data_byte[1:0]);
                            n_phase = PH_COUNT;
                        end else begin
                            status = ST_BAD_TOKEN;
                        end
                    end
                    PH_COUNT: begin
                        n_rem = i_data_byte;
                        if (i_data_byte == 8'd0) begin
                            n_phase = PH_TOKEN;
                        end else if (r_kind == KIND_LITERAL) begin
                            n_phase = PH_LIT_LO;
                        end else begin
                            n_phase = PH_COPY;
                        end
                    end
                    PH_LIT_LO: begin
                        n_lo    = i_data_byte;
                        n_phase = PH_LIT_HI;
                    end
                    PH_LIT_HI: begin
                        emit    = 1'b1;
                        lit_val = {i_data_byte, r_lo};
                        n_rem   = rem_dec;
                        n_phase = (rem_dec == 8'd0) ? PH_TOKEN : PH_LIT_LO;
                    end
                    default: begin
                        // byte while copy pixels are pending
                        status = ST_ORDER;
                    end
                endcase
            end
            OP_PULL: begin
                if (r_phase == PH_COPY) begin
                    emit  = 1'b1;
                    copy  = 1'b1;
                    n_rem = rem_dec;
                    if (rem_dec == 8'd0) begin
                        n_phase = PH_TOKEN;
                    end
                    if (!src_ok) begin
                        status = ST_OUTSIDE;
                    end
                end else begin
                    status = ST_ORDER;
                end
            end
            OP_EOF: begin
                if (r_phase != PH_TOKEN) begin
                    status = ST_ORDER;
                end
                n_bank  = ~r_bank;
                n_x     = '0;
                n_y     = '0;
                n_pos   = '0;
                n_phase = PH_TOKEN;
                n_rem   = '0;
            end
            default: begin
                status = ST_ORDER;
            end
        endcase

        // Advance in raster order, wrap at row end and frame end
        if (emit) begin
            if (r_x == X_W'(FRAME_WIDTH - 1)) begin
                n_x = '0;
                if (r_y == Y_W'(FRAME_HEIGHT - 1)) begin
                    n_y   = '0;
                    n_pos = '0;
                end else begin
                    n_y   = r_y + 1'b1;
                    n_pos = r_pos + 1'b1;
                end
            end else begin
                n_x   = r_x + 1'b1;
                n_pos = r_pos + 1'b1;
            end
        end
    end

    // Word handed to the read-data stage
    always_comb begin
        n_s1.pixel_valid = emit;
        n_s1.x           = emit ? r_x : '0;
        n_s1.y           = emit ? r_y : '0;
        n_s1.value       = lit_val;
        n_s1.from_ram    = copy && src_ok;
        n_s1.waddr       = cur_base + ADDR_W'(r_pos);
        n_s1.run_pending = (n_phase == PH_COPY);
        n_s1.status      = status;
    end

    // Frame store read for a copy pixel from the previous bank
    assign o_rd_en   = i_in_fire && copy && src_ok;
    assign o_rd_addr = prev_base + ADDR_W'(r_pos) + sel_lin;
    assign o_s1      = r_s1;

    // Decode state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TOKEN;
            r_kind  <= KIND_ZERO;
            r_rem   <= '0;
            r_lo    <= '0;
            r_x     <= '0;
            r_y     <= '0;
            r_pos   <= '0;
            r_bank  <= 1'b0;
        end else if (i_in_fire) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_rem   <= n_rem;
            r_lo    <= n_lo;
            r_x     <= n_x;
            r_y     <= n_y;
            r_pos   <= n_pos;
            r_bank  <= n_bank;
        end
    end

    // Offset registers with their precomputed linear distance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ax    <= '0;
            r_ay    <= '0;
            r_bx    <= '0;
            r_by    <= '0;
            r_lin_a <= '0;
            r_lin_b <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_OFFSET_A_X: begin
                    r_ax    <= i_cfg_data[OFFX_W-1:0];
                    r_lin_a <= lin_offset(i_cfg_data[OFFX_W-1:0], r_ay);
                end
                REG_OFFSET_A_Y: begin
                    r_ay    <= i_cfg_data[OFFY_W-1:0];
                    r_lin_a <= lin_offset(r_ax, i_cfg_data[OFFY_W-1:0]);
                end
                REG_OFFSET_B_X: begin
                    r_bx    <= i_cfg_data[OFFX_W-1:0];
                    r_lin_b <= lin_offset(i_cfg_data[OFFX_W-1:0], r_by);
                end
                REG_OFFSET_B_Y: begin
                    r_by    <= i_cfg_data[OFFY_W-1:0];
                    r_lin_b <= lin_offset(r_bx, i_cfg_data[OFFY_W-1:0]);
                end
                default: begin
                    r_ax <= r_ax;
                end
            endcase
        end
    end

    // Payload register, loaded on accept
    always_ff @(posedge i_clk) begin
        if (i_in_fire) begin
            r_s1 <= n_s1;
        end
    end
endmodule

// ----- hdl/delta_frame_decoder.sv -----
// Delta frame decoder top level: decode stage, two-bank frame store, output register.
// Path: an accepted word is held in the read-data stage, then in the output register.
// Throughput: one word per cycle unless stalled; copies read the store, pixels write it.
// Reset: synchronous, active low; then a clearing pass zeroes the frame store, one entry
// a cycle over all 614400 entries, during which no input word is taken (config is taken).
`include "delta_frame_decoder_defines.svh"

module delta_frame_decoder (
    input  logic      i_clk,
    input  logic      i_rst_n,
    dfd_in_if.sink    i_in,
    dfd_cfg_if.sink   i_cfg,
    dfd_out_if.source o_out
);
    import dfd_pkg::*;

    logic              in_fire;
    logic              adv_s1;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [PIX_W-1:0]  ram_rdata;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  s1_value;
    t_s1               s1;

    logic              r_s1_valid;
    logic              r_clr_done;
    logic [ADDR_W-1:0] r_clr_addr;

    logic                r_out_valid;
    logic                r_pix_valid;
    logic [X_W-1:0]      r_pix_x;
    logic [Y_W-1:0]      r_pix_y;
    logic [PIX_W-1:0]    r_pix_value;
    logic                r_run_pending;
    logic [STATUS_W-1:0] r_status;

    // Handshakes: the read-data stage moves on when the output register is free
    assign adv_s1      = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = r_clr_done && (!r_s1_valid || adv_s1);
    assign in_fire     = i_in.valid && i_in.ready;
    assign i_cfg.ready = 1'b1;

    dfd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_fire   (in_fire),
        .i_op        (i_in.op),
        .i_data_byte (i_in.data_byte),
        .i_cfg_we    (i_cfg.valid && i_cfg.ready),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .o_rd_en     (rd_en),
        .o_rd_addr   (rd_addr),
        .o_s1        (s1)
    );

    // Pixel value: store data for an in-frame copy, else the literal (zero otherwise)
    assign s1_value = s1.from_ram ? ram_rdata : s1.value;

    // Write port: clearing pass first, then one pixel per pixel word leaving the stage
    assign ram_we    = !r_clr_done || (adv_s1 && s1.pixel_valid);
    assign ram_waddr = r_clr_done ? s1.waddr : r_clr_addr;
    assign ram_wdata = r_clr_done ? s1_value : '0;

    dfd_ram #(
        .WIDTH (PIX_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    // Clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_done <= 1'b0;
            r_clr_addr <= '0;
        end else if (!r_clr_done) begin
            if (r_clr_addr == ADDR_W'(STORE_DEPTH - 1)) begin
                r_clr_done <= 1'b1;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Occupancy of the read-data stage and of the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (adv_s1) begin
                r_s1_valid <= 1'b0;
            end
            if (adv_s1) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (adv_s1) begin
            r_pix_valid   <= s1.pixel_valid;
            r_pix_x       <= s1.x;
            r_pix_y       <= s1.y;
            r_pix_value   <= s1_value;
            r_run_pending <= s1.run_pending;
            r_status      <= s1.status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.pixel_valid = r_pix_valid;
    assign o_out.pixel_x     = r_pix_x;
    assign o_out.pixel_y     = r_pix_y;
    assign o_out.pixel_value = r_pix_value;
    assign o_out.run_pending = r_run_pending;
    assign o_out.status      = r_status;

    // A pixel write never lands on the entry being read in the same cycle
    `DFD_ASSERT_IMPLY(a_no_rw_collision, i_clk, i_rst_n, ram_we && rd_en, ram_waddr != rd_addr, "frame store write and read hit the same entry")
    // Read data of a stalled word must hold until it leaves
    `DFD_ASSERT_NEXT(a_rdata_held, i_clk, i_rst_n, r_s1_valid && !adv_s1, $stable(ram_rdata), "frame store read data changed under a stalled word")
    // Decoded pixels stay inside the frame
    `DFD_ASSERT_IMPLY(a_pixel_in_frame, i_clk, i_rst_n, o_out.valid && o_out.pixel_valid, (o_out.pixel_x < X_W'(FRAME_WIDTH)) && (o_out.pixel_y < Y_W'(FRAME_HEIGHT)), "pixel position outside the frame")
    // An out-of-frame source still yields a zero pixel
    `DFD_ASSERT_IMPLY(a_outside_zero, i_clk, i_rst_n, o_out.valid && (o_out.status == ST_OUTSIDE), o_out.pixel_valid && (o_out.pixel_value == '0), "out-of-frame copy without a zero pixel")
endmodule

// ----- verif/tb_delta_frame_decoder.sv -----
// Testbench for delta_frame_decoder: drives compressed bytes, pulls and end of frame words,
// predicts every result word and checks it field by field. Depends on dfd_pkg and dfd_ifs.
`timescale 1ns / 1ps

module tb_delta_frame_decoder;
    import dfd_pkg::*;

    // One result word of the decoder
    typedef struct {
        logic             pix_valid;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic [PIX_W-1:0] value;
        logic             run_pending;
        logic [1:0]       status;
    } t_pixel_word;

    // Mirrors the decoder state and the two-bank frame store; queues expected result words
    class pixel_predictor;
        bit [OFFX_W-1:0] off_ax, off_bx;
        bit [OFFY_W-1:0] off_ay, off_by;
        t_phase          phase = PH_TOKEN;
        t_kind           kind = KIND_ZERO;
        bit [7:0]        remaining;
        bit [7:0]        lit_lo;
        int              wx, wy;
        bit              bank;
        bit [PIX_W-1:0]  frame_mem [int];
        t_pixel_word     nxt;
        t_pixel_word     expected_pixels [$];
        int              mismatches;

        function void write_offset(t_cfg_reg idx, bit [CFG_DATA_W-1:0] d);
            case (idx)
                REG_OFFSET_A_X: off_ax = d;
                REG_OFFSET_A_Y: off_ay = d[OFFY_W-1:0];
                REG_OFFSET_B_X: off_bx = d;
                REG_OFFSET_B_Y: off_by = d[OFFY_W-1:0];
            endcase
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction

        // Store the pixel in the current bank, fill the result, advance in raster order
        function void put_pixel(bit [PIX_W-1:0] v);
            frame_mem[int'(bank) * BANK_SIZE + wy * FRAME_WIDTH + wx] = v;
            nxt.pix_valid = 1'b1;
            nxt.x = X_W'(wx);
            nxt.y = Y_W'(wy);
            nxt.value = v;
            wx++;
            if (wx >= FRAME_WIDTH) begin
                wx = 0;
                wy++;
                if (wy >= FRAME_HEIGHT) wy = 0;
            end
            remaining--;
        endfunction

        function void note_word(t_op op, bit [7:0] b);
            int ox, oy, sx, sy, src;
            bit [PIX_W-1:0] v;
            nxt.pix_valid = 1'b0;
            nxt.x = '0;
            nxt.y = '0;
            nxt.value = '0;
            nxt.status = ST_OK;
            case (op)
                OP_BYTE: begin
                    case (phase)
                        PH_TOKEN: begin
                            if (b >= TOK_COPY_ZERO) begin
                                kind = t_kind'(b[1:0]);
                                phase = PH_COUNT;
                            end else begin
                                nxt.status = ST_BAD_TOKEN;
                            end
                        end
                        PH_COUNT: begin
                            remaining = b;
                            if (b == 8'd0) phase = PH_TOKEN;
                            else if (kind == KIND_LITERAL) phase = PH_LIT_LO;
                            else phase = PH_COPY;
                        end
                        PH_LIT_LO: begin
                            lit_lo = b;
                            phase = PH_LIT_HI;
                        end
                        PH_LIT_HI: begin
                            put_pixel({b, lit_lo});
                            phase = (remaining == 8'd0) ? PH_TOKEN : PH_LIT_LO;
                        end
                        default: nxt.status = ST_ORDER;
                    endcase
                end
                OP_PULL: begin
                    if (phase == PH_COPY) begin
                        ox = 0;
                        oy = 0;
                        if (kind == KIND_A) begin
                            ox = $signed(off_ax);
                            oy = $signed(off_ay);
                        end else if (kind == KIND_B) begin
                            ox = $signed(off_bx);
                            oy = $signed(off_by);
                        end
                        sx = wx + ox;
                        sy = wy + oy;
                        v = '0;
                        if (sx >= 0 && sx < FRAME_WIDTH && sy >= 0 && sy < FRAME_HEIGHT) begin
                            // Read the previous frame, i.e. the other bank
                            src = int'(!bank) * BANK_SIZE + sy * FRAME_WIDTH + sx;
                            if (frame_mem.exists(src)) v = frame_mem[src];
                        end else begin
                            nxt.status = ST_OUTSIDE;
                        end
                        put_pixel(v);
                        if (remaining == 8'd0) phase = PH_TOKEN;
                    end else begin
                        nxt.status = ST_ORDER;
                    end
                end
                OP_EOF: begin
                    if (phase != PH_TOKEN) nxt.status = ST_ORDER;
                    bank = ~bank;
                    wx = 0;
                    wy = 0;
                    phase = PH_TOKEN;
                    remaining = '0;
                end
                default: nxt.status = ST_ORDER;
            endcase
            nxt.run_pending = (phase == PH_COPY);
            expected_pixels.push_back(nxt);
        endfunction

        function void compare_field(string name, logic [PIX_W-1:0] want,
                                    logic [PIX_W-1:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_pixel(t_pixel_word got);
            t_pixel_word want;
            if (expected_pixels.size() == 0) begin
                mismatches++;
                $display("%0t: result word with none expected, expected none actual x=%0d y=%0d v=%0h",
                         $time, got.x, got.y, got.value);
                return;
            end
            want = expected_pixels.pop_front();
            compare_field("pixel_valid", want.pix_valid, got.pix_valid);
            compare_field("pixel_x", want.x, got.x);
            compare_field("pixel_y", want.y, got.y);
            compare_field("pixel_value", want.value, got.value);
            compare_field("run_pending", want.run_pending, got.run_pending);
            compare_field("status", want.status, got.status);
        endfunction
    endclass

    // Silent cycles allowed: covers the store clearing pass after reset several times over
    localparam int STALL_LIMIT = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    int send_idle_pct = 18;
    int recv_idle_pct = 56;
    int words_sent;

    pixel_predictor predictor = new;

    dfd_in_if  in_if ();
    dfd_out_if out_if ();
    dfd_cfg_if cfg_if ();

    delta_frame_decoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .i_cfg   (cfg_if),
        .o_out   (out_if)
    );

    always #5 i_clk = ~i_clk;

    // Offer one input word, idling at random first, and hold it until taken
    task automatic send_word(input t_op op, input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid     <= 1'b1;
        in_if.op        <= op;
        in_if.data_byte <= b;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        predictor.note_word(op, b);
        words_sent++;
    endtask

    function automatic int pick_signed(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    // Write all four offset registers; the y registers get a random unused top bit
    task automatic load_offsets(input int ax, input int ay, input int bx, input int by);
        int vals[4];
        logic [CFG_DATA_W-1:0] d;
        vals = '{ax, ay, bx, by};
        for (int i = 0; i < 4; i++) begin
            d = CFG_DATA_W'(vals[i]);
            if (i == int'(REG_OFFSET_A_Y) || i == int'(REG_OFFSET_B_Y))
                d[CFG_DATA_W-1] = 1'($urandom_range(1));
            cfg_if.index <= t_cfg_reg'(i);
            cfg_if.data  <= d;
            cfg_if.valid <= 1'b1;
            do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
            predictor.write_offset(t_cfg_reg'(i), d);
        end
        cfg_if.valid <= 1'b0;
    endtask

    // Drop valid and wait until every expected word has come back
    task automatic finish_phase();
        in_if.valid <= 1'b0;
        while (predictor.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Field extremes and each corner case of the token grammar
    task automatic run_directed();
        send_word(OP_BYTE, 8'd0);        // bad token, lowest byte
        send_word(OP_BYTE, 8'd251);      // bad token, just below the first token
        send_word(OP_PULL, 8'hFF);       // pull with no run pending
        send_word(OP_RSVD, 8'h00);       // unused op
        send_word(OP_BYTE, TOK_LITERAL);
        send_word(OP_BYTE, 8'd3);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'h00);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'hFF);
        send_word(OP_BYTE, 8'h5A);
        send_word(OP_BYTE, 8'hA5);
        send_word(OP_BYTE, TOK_COPY_ZERO);
        send_word(OP_BYTE, 8'd0);        // zero count
        send_word(OP_BYTE, TOK_COPY_A);
        send_word(OP_BYTE, 8'd2);
        send_word(OP_BYTE, 8'h80);       // byte while a copy run is pending
        send_word(OP_PULL, 8'h00);
        send_word(OP_PULL, 8'h00);
        send_word(OP_BYTE, TOK_COPY_B);  // offset B points outside the frame
        send_word(OP_BYTE, 8'd1);
        send_word(OP_PULL, 8'h00);
        send_word(OP_BYTE, TOK_LITERAL);
        send_word(OP_BYTE, 8'd1);
        send_word(OP_BYTE, 8'h33);
        send_word(OP_EOF, 8'h00);        // end of frame inside a literal
    endtask

    // One frame of mostly well-formed tokens with some noise and early cuts
    task automatic send_frame();
        int ntok, cnt, cut_at, r;
        bit cut;
        logic [7:0] tok;
        ntok = $urandom_range(1, 5);
        repeat (ntok) begin
            if ($urandom_range(99) < 6) send_word(OP_BYTE, 8'($urandom_range(251)));
            if ($urandom_range(99) < 3) send_word(OP_RSVD, 8'($urandom_range(255)));
            if ($urandom_range(99) < 3) send_word(OP_PULL, 8'($urandom_range(255)));
            tok = TOK_COPY_ZERO + 8'($urandom_range(3));
            r = $urandom_range(99);
            cnt = (r < 5) ? 0 : (r < 9) ? $urandom_range(128, 255) : $urandom_range(1, 6);
            cut = ($urandom_range(99) < 5);
            cut_at = $urandom_range(cnt);
            send_word(OP_BYTE, tok);
            if (cut && cut_at == 0) begin
                send_word(OP_EOF, 8'($urandom_range(255)));
                return;
            end
            send_word(OP_BYTE, 8'(cnt));
            for (int i = 0; i < cnt; i++) begin
                if (tok == TOK_LITERAL) begin
                    send_word(OP_BYTE, 8'($urandom_range(255)));
                    if (cut && cut_at == i + 1) begin
                        send_word(OP_EOF, 8'($urandom_range(255)));
                        return;
                    end
                    send_word(OP_BYTE, 8'($urandom_range(255)));
                end else begin
                    if ($urandom_range(99) < 6) send_word(OP_BYTE, 8'($urandom_range(255)));
                    if (cut && cut_at == i + 1) begin
                        send_word(OP_EOF, 8'($urandom_range(255)));
                        return;
                    end
                    send_word(OP_PULL, 8'($urandom_range(255)));
                end
            end
        end
        // Skip the end of frame now and then so frames grow longer
        if ($urandom_range(99) < 80) send_word(OP_EOF, 8'($urandom_range(255)));
    endtask

    task automatic send_frames(input int n_words);
        int start;
        start = words_sent;
        while (words_sent - start < n_words) send_frame();
    endtask

    // Result side: check each accepted word, stall at random
    initial begin
        t_pixel_word got;
        out_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
                got.pix_valid   = out_if.pixel_valid;
                got.x           = out_if.pixel_x;
                got.y           = out_if.pixel_y;
                got.value       = out_if.pixel_value;
                got.run_pending = out_if.run_pending;
                got.status      = out_if.status;
                predictor.check_pixel(got);
            end
            out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: end the run after too many cycles with no handshake anywhere
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid === 1'b1 && in_if.ready === 1'b1) ||
                (out_if.valid === 1'b1 && out_if.ready === 1'b1) ||
                (cfg_if.valid === 1'b1 && cfg_if.ready === 1'b1))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        i_rst_n         <= 1'b0;
        in_if.valid     <= 1'b0;
        in_if.op        <= OP_BYTE;
        in_if.data_byte <= '0;
        cfg_if.valid    <= 1'b0;
        cfg_if.index    <= REG_OFFSET_A_X;
        cfg_if.data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Sender idles lightly, receiver heavily
        load_offsets(2, 0, -640, -480);
        run_directed();
        send_frames(350);
        finish_phase();

        // Roles swapped; offset A at its upper extremes
        send_idle_pct = 56;
        recv_idle_pct = 18;
        load_offsets(639, 479, pick_signed(-4, 4), pick_signed(-1, 1));
        send_frames(350);
        finish_phase();

        // Full speed: random frames with random offsets
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_offsets(pick_signed(-640, 639), pick_signed(-480, 479),
                     pick_signed(-4, 4), pick_signed(-2, 2));
        send_frames(350);
        finish_phase();

        repeat (8) @(posedge i_clk);
        if (predictor.mismatches == 0 && predictor.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dfd_pkg.sv
hdl/dfd_ifs.sv
hdl/dfd_ram.sv
hdl/dfd_ctrl.sv
hdl/delta_frame_decoder.sv
verif/tb_delta_frame_decoder.sv
